### design/pwbt_pkg.sv
`timescale 1ns / 1ps
// Package for the pulse-width byte transmitter.
// Holds widths, segment kind codes, register indexes and the controller/datapath structs.
// No dependencies.
package pwbt_pkg;

	localparam int MAX_SYNC_PULSES = 15;
	localparam int DURATION_BITS   = 16;
	localparam int BITS_PER_BYTE   = 8;

	localparam int DUR_W      = DURATION_BITS;
	localparam int BYTE_W     = BITS_PER_BYTE;
	localparam int BIT_CNT_W  = $clog2(BITS_PER_BYTE);
	localparam int SYNC_REG_W = 4;
	localparam int SYNC_CNT_W = $clog2(MAX_SYNC_PULSES + 1);
	localparam int KIND_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = DUR_W;

	typedef logic [KIND_W-1:0] seg_kind_t;

	// Segment kinds as they appear on the output.
	localparam seg_kind_t KIND_LEAD  = 3'd0;
	localparam seg_kind_t KIND_HIGH  = 3'd1;
	localparam seg_kind_t KIND_SYNC  = 3'd2;
	localparam seg_kind_t KIND_ZERO  = 3'd3;
	localparam seg_kind_t KIND_ONE   = 3'd4;
	localparam seg_kind_t KIND_FINAL = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_TIME = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_BIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_BIT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_BIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_REPS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load;
		logic      emit;
		logic      shift;
		logic      level;
		seg_kind_t kind;
		logic      last_seg;
	} pwbt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [SYNC_CNT_W-1:0] syncs;
		logic                  data_msb;
		logic                  last_byte;
	} pwbt_status_t;

	// Clamp the programmed sync count to the supported maximum.
	function automatic logic [SYNC_CNT_W-1:0] clamp_syncs(input logic [SYNC_REG_W-1:0] v);
		if (int'(v) > MAX_SYNC_PULSES) begin
			return SYNC_CNT_W'(MAX_SYNC_PULSES);
		end
		return SYNC_CNT_W'(v);
	endfunction

endpackage

### design/pwbt_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the pulse-width byte transmitter.
// Depends on pwbt_pkg for field widths.
interface pwbt_byte_if;
	logic                      valid;
	logic                      ready;
	logic [pwbt_pkg::BYTE_W-1:0] data_byte;
	logic                      last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pwbt_seg_if;
	logic                         valid;
	logic                         ready;
	logic                         line_level;
	logic [pwbt_pkg::DUR_W-1:0]   duration_us;
	logic [pwbt_pkg::KIND_W-1:0]  segment_kind;
	logic                         last_segment;

	modport source (output valid, output line_level, output duration_us,
		output segment_kind, output last_segment, input ready);
	modport sink (input valid, input line_level, input duration_us,
		input segment_kind, input last_segment, output ready);
endinterface

### design/pulse_width_byte_transmitter.sv
`timescale 1ns / 1ps
// The first segment of a request is emitted from the state entered on acceptance.
// Throughput: one segment per cycle while the sink takes them; a request producing n segments
// (16 + 2 * sync count, plus 1 lead low on a new message, plus 2 for a last byte; at most 49)
// occupies the sequencer until its last segment is emitted; no new request is taken before then.
// Reset: configuration returns to 10, 20, 40, 80, 1, 0, no message open, output empty.
// Top level of the pulse-width byte transmitter; depends on pwbt_pkg, pwbt_if, pwbt_ctrl, pwbt_dp.
module pulse_width_byte_transmitter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pwbt_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pwbt_pkg::CFG_DATA_W-1:0] cfg_wdata,
	pwbt_byte_if.sink                       byte_in,
	pwbt_seg_if.source                      seg_out
);
	import pwbt_pkg::*;

	pwbt_cmd_t    cmd;
	pwbt_status_t status;

	// Sequencer.
	pwbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (byte_in.valid),
		.in_ready  (byte_in.ready),
		.out_valid (seg_out.valid),
		.out_ready (seg_out.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Registers, duration selection and output segment.
	pwbt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.data_byte    (byte_in.data_byte),
		.last_byte    (byte_in.last_byte),
		.cmd          (cmd),
		.status       (status),
		.line_level   (seg_out.line_level),
		.duration_us  (seg_out.duration_us),
		.segment_kind (seg_out.segment_kind),
		.last_segment (seg_out.last_segment)
	);

endmodule

### design/pwbt_dp.sv
`timescale 1ns / 1ps
// Datapath of the pulse-width byte transmitter: configuration registers,
// byte shift register, duration selection and the output segment register.
// Depends on pwbt_pkg.
module pwbt_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pwbt_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [pwbt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic [pwbt_pkg::BYTE_W-1:0]       data_byte,
	input  logic                              last_byte,
	input  pwbt_pkg::pwbt_cmd_t               cmd,
	output pwbt_pkg::pwbt_status_t            status,
	output logic                              line_level,
	output logic [pwbt_pkg::DUR_W-1:0]        duration_us,
	output logic [pwbt_pkg::KIND_W-1:0]       segment_kind,
	output logic                              last_segment
);
	import pwbt_pkg::*;

	logic [DUR_W-1:0]      high_time_q;
	logic [DUR_W-1:0]      zero_bit_q;
	logic [DUR_W-1:0]      one_bit_q;
	logic [DUR_W-1:0]      sync_bit_q;
	logic [SYNC_REG_W-1:0] sync_reps_q;
	logic                  invert_q;

	logic [BYTE_W-1:0]     byte_q;
	logic                  last_q;

	logic                  level_q;
	logic [DUR_W-1:0]      dur_q;
	seg_kind_t             kind_q;
	logic                  seg_last_q;

	logic [DUR_W-1:0]      period;
	logic [DUR_W-1:0]      low_len;
	logic [DUR_W-1:0]      dur_sel;

	// Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_time_q <= DUR_W'(10);
			zero_bit_q  <= DUR_W'(20);
			one_bit_q   <= DUR_W'(40);
			sync_bit_q  <= DUR_W'(80);
			sync_reps_q <= SYNC_REG_W'(1);
			invert_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_HIGH_TIME: high_time_q <= cfg_wdata;
				REG_ZERO_BIT:  zero_bit_q  <= cfg_wdata;
				REG_ONE_BIT:   one_bit_q   <= cfg_wdata;
				REG_SYNC_BIT:  sync_bit_q  <= cfg_wdata;
				REG_SYNC_REPS: sync_reps_q <= cfg_wdata[SYNC_REG_W-1:0];
				REG_INVERT:    invert_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Byte shift register, MSB leaves first.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= data_byte;
			last_q <= last_byte;
		end else if (cmd.shift) begin
			byte_q <= {byte_q[BYTE_W-2:0], 1'b0};
		end
	end

	// Lead/high: high time; lows: bit period less high time, saturating at zero; final: zero.
	always_comb begin
		unique case (cmd.kind)
			KIND_SYNC: period = sync_bit_q;
			KIND_ONE:  period = one_bit_q;
			default:   period = zero_bit_q;
		endcase
		low_len = (period > high_time_q) ? (period - high_time_q) : '0;
		unique case (cmd.kind)
			KIND_LEAD, KIND_HIGH:          dur_sel = high_time_q;
			KIND_SYNC, KIND_ZERO, KIND_ONE: dur_sel = low_len;
			default:                        dur_sel = '0;
		endcase
	end

	// Output segment register, loaded once per emitted segment.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			level_q    <= cmd.level ^ invert_q;
			dur_q      <= dur_sel;
			kind_q     <= cmd.kind;
			seg_last_q <= cmd.last_seg;
		end
	end

	assign status.syncs     = clamp_syncs(sync_reps_q);
	assign status.data_msb  = byte_q[BYTE_W-1];
	assign status.last_byte = last_q;

	assign line_level   = level_q;
	assign duration_us  = dur_q;
	assign segment_kind = kind_q;
	assign last_segment = seg_last_q;

endmodule

### design/pwbt_ctrl.sv
`timescale 1ns / 1ps
// Controller of the pulse-width byte transmitter: segment sequencer,
// sync and bit counters, message-open flag and output valid.
// Depends on pwbt_pkg.
module pwbt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  pwbt_pkg::pwbt_status_t status,
	output pwbt_pkg::pwbt_cmd_t    cmd
);
	import pwbt_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_LEAD    = 3'd1;
	localparam logic [2:0] ST_SYNC_HI = 3'd2;
	localparam logic [2:0] ST_SYNC_LO = 3'd3;
	localparam logic [2:0] ST_BIT_HI  = 3'd4;
	localparam logic [2:0] ST_BIT_LO  = 3'd5;
	localparam logic [2:0] ST_STOP_HI = 3'd6;
	localparam logic [2:0] ST_FINAL   = 3'd7;

	logic [2:0]            state_q;
	logic [2:0]            state_d;
	logic [SYNC_CNT_W-1:0] sync_cnt_q;
	logic [BIT_CNT_W-1:0]  bit_cnt_q;
	logic                  open_q;
	logic                  out_valid_q;
	logic                  slot_free;
	logic                  emit;
	logic                  sync_done;
	logic                  bits_done;
	logic [2:0]            first_body;

	assign slot_free  = !out_valid_q || out_ready;
	assign emit       = (state_q != ST_IDLE) && slot_free;
	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign sync_done  = (sync_cnt_q == status.syncs - SYNC_CNT_W'(1));
	assign bits_done  = (bit_cnt_q == BIT_CNT_W'(BITS_PER_BYTE - 1));
	assign first_body = (status.syncs != '0) ? ST_SYNC_HI : ST_BIT_HI;

	// Segment command for the current state.
	always_comb begin
		cmd          = '0;
		cmd.load     = in_valid && in_ready;
		cmd.emit     = emit;
		cmd.kind     = KIND_LEAD;
		unique case (state_q)
			ST_IDLE: ;
			ST_LEAD: cmd.kind = KIND_LEAD;
			ST_SYNC_HI, ST_BIT_HI, ST_STOP_HI: begin
				cmd.level = 1'b1;
				cmd.kind  = KIND_HIGH;
			end
			ST_SYNC_LO: cmd.kind = KIND_SYNC;
			ST_BIT_LO: begin
				cmd.kind     = status.data_msb ? KIND_ONE : KIND_ZERO;
				cmd.shift    = emit;
				cmd.last_seg = bits_done && !status.last_byte;
			end
			ST_FINAL: begin
				cmd.kind     = KIND_FINAL;
				cmd.last_seg = 1'b1;
			end
			default: ;
		endcase
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_valid) state_d = open_q ? first_body : ST_LEAD;
			ST_LEAD:    if (emit) state_d = first_body;
			ST_SYNC_HI: if (emit) state_d = ST_SYNC_LO;
			ST_SYNC_LO: if (emit) state_d = sync_done ? ST_BIT_HI : ST_SYNC_HI;
			ST_BIT_HI:  if (emit) state_d = ST_BIT_LO;
			ST_BIT_LO: begin
				if (emit) begin
					if (!bits_done) begin
						state_d = ST_BIT_HI;
					end else begin
						state_d = status.last_byte ? ST_STOP_HI : ST_IDLE;
					end
				end
			end
			ST_STOP_HI: if (emit) state_d = ST_FINAL;
			ST_FINAL:   if (emit) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// State, counters, message flag and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sync_cnt_q  <= '0;
			bit_cnt_q   <= '0;
			open_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				open_q     <= 1'b1;
				sync_cnt_q <= '0;
				bit_cnt_q  <= '0;
			end
			if (emit && state_q == ST_SYNC_LO) begin
				sync_cnt_q <= sync_cnt_q + SYNC_CNT_W'(1);
			end
			if (emit && state_q == ST_BIT_LO) begin
				bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
			end
			if (emit && state_q == ST_FINAL) begin
				open_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// An accepted request always starts a segment sequence.
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q != ST_IDLE)
		else $error("accepted request did not start the sequencer");

	// The segment flagged last returns the sequencer to idle.
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && cmd.last_seg) |=> state_q == ST_IDLE)
		else $error("sequencer kept running after the last segment");

	// The final low closes the message.
	a_final_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && state_q == ST_FINAL) |=> !open_q)
		else $error("message still open after the final low");

	// The sync counter stays below the programmed count.
	a_sync_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SYNC_HI || state_q == ST_SYNC_LO) |-> sync_cnt_q < status.syncs)
		else $error("sync counter overran the sync count");

endmodule

### tb/pulse_width_byte_transmitter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pulse-width byte transmitter.
// Predicts every line segment of each accepted byte and checks the segment stream in order.
// Depends on pwbt_pkg, pwbt_if and the pulse_width_byte_transmitter RTL.
module pulse_width_byte_transmitter_tb;
	import pwbt_pkg::*;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_INVERT + 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = REG_INVERT + 3'd2;

	typedef struct {
		logic [DUR_W-1:0]      high_time;
		logic [DUR_W-1:0]      zero_bit;
		logic [DUR_W-1:0]      one_bit;
		logic [DUR_W-1:0]      sync_bit;
		logic [SYNC_REG_W-1:0] sync_reps;
		logic                  invert;
	} line_cfg_t;

	typedef struct {
		logic             level;
		logic [DUR_W-1:0] dur;
		seg_kind_t        kind;
		logic             last;
	} segment_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pwbt_byte_if byte_ch ();
	pwbt_seg_if  seg_ch ();

	pulse_width_byte_transmitter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.byte_in  (byte_ch),
		.seg_out  (seg_ch)
	);

	// Shadow copy of the line settings and of the open-message flag.
	line_cfg_t line_cfg;
	logic      frame_open;
	segment_t  pending_segments[$];

	int  mismatch_count   = 0;
	int  segments_checked = 0;
	int  requests_sent    = 0;
	int  settings_applied = 0;
	int  cycle_count      = 0;
	int  stall_left       = 0;
	logic idling_on       = 1'b1;

	segment_t got_seg;
	segment_t want_seg;

	// Free-running clock, 10 ns period.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run-length guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d segments still pending",
				cycle_count, pending_segments.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// Segment sink: random stall bursts while idling is enabled.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			seg_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idling_on && $urandom_range(0, 7) == 0) begin
			seg_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 15);
		end else begin
			seg_ch.ready <= 1'b1;
		end
	end

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// Compare each accepted segment with the oldest predicted one.
	always @(posedge clk) begin
		if (arst_n && seg_ch.valid === 1'b1 && seg_ch.ready === 1'b1) begin
			segments_checked++;
			got_seg.level = seg_ch.line_level;
			got_seg.dur   = seg_ch.duration_us;
			got_seg.kind  = seg_ch.segment_kind;
			got_seg.last  = seg_ch.last_segment;
			if (pending_segments.size() == 0) begin
				report_mismatch($sformatf("segment kind %0d dur %0d with no request pending",
					got_seg.kind, got_seg.dur));
			end else begin
				want_seg = pending_segments.pop_front();
				if (got_seg.level !== want_seg.level)
					report_mismatch($sformatf("line_level %b, predicted %b (kind %0d)",
						got_seg.level, want_seg.level, want_seg.kind));
				if (got_seg.dur !== want_seg.dur)
					report_mismatch($sformatf("duration_us %0d, predicted %0d (kind %0d)",
						got_seg.dur, want_seg.dur, want_seg.kind));
				if (got_seg.kind !== want_seg.kind)
					report_mismatch($sformatf("segment_kind %0d, predicted %0d",
						got_seg.kind, want_seg.kind));
				if (got_seg.last !== want_seg.last)
					report_mismatch($sformatf("last_segment %b, predicted %b (kind %0d)",
						got_seg.last, want_seg.last, want_seg.kind));
			end
		end
	end

	// Low part of a bit: the period minus the high time, never below zero.
	function automatic logic [DUR_W-1:0] low_part(input logic [DUR_W-1:0] period);
		return (period > line_cfg.high_time) ? period - line_cfg.high_time : '0;
	endfunction

	function automatic segment_t make_segment(input logic level, input logic [DUR_W-1:0] dur,
			input seg_kind_t kind);
		segment_t s;
		s.level = level ^ line_cfg.invert;
		s.dur   = dur;
		s.kind  = kind;
		s.last  = 1'b0;
		return s;
	endfunction

	// Expand one byte request into the segments it must produce.
	function automatic void expand_request(input logic [BYTE_W-1:0] data, input logic closes);
		segment_t segs[$];
		int n_sync;
		n_sync = (int'(line_cfg.sync_reps) > MAX_SYNC_PULSES) ? MAX_SYNC_PULSES
			: int'(line_cfg.sync_reps);
		if (!frame_open) begin
			segs.push_back(make_segment(1'b0, line_cfg.high_time, KIND_LEAD));
			frame_open = 1'b1;
		end
		for (int i = 0; i < n_sync; i++) begin
			segs.push_back(make_segment(1'b1, line_cfg.high_time, KIND_HIGH));
			segs.push_back(make_segment(1'b0, low_part(line_cfg.sync_bit), KIND_SYNC));
		end
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			segs.push_back(make_segment(1'b1, line_cfg.high_time, KIND_HIGH));
			if (data[i])
				segs.push_back(make_segment(1'b0, low_part(line_cfg.one_bit), KIND_ONE));
			else
				segs.push_back(make_segment(1'b0, low_part(line_cfg.zero_bit), KIND_ZERO));
		end
		if (closes) begin
			segs.push_back(make_segment(1'b1, line_cfg.high_time, KIND_HIGH));
			segs.push_back(make_segment(1'b0, '0, KIND_FINAL));
			frame_open = 1'b0;
		end
		segs[segs.size() - 1].last = 1'b1;
		foreach (segs[i]) pending_segments.push_back(segs[i]);
	endfunction

	// Present one byte request, with an optional gap before it, and wait for acceptance.
	task automatic send_request(input logic [BYTE_W-1:0] data, input logic closes);
		int gap;
		@(negedge clk);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			byte_ch.valid <= 1'b0;
			gap = $urandom_range(1, 16);
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= data;
		byte_ch.last_byte <= closes;
		do @(posedge clk); while (byte_ch.ready !== 1'b1);
		expand_request(data, closes);
		requests_sent++;
	endtask

	// Stop sending and wait until every predicted segment has come out.
	task automatic wait_drained;
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (pending_segments.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			REG_HIGH_TIME: line_cfg.high_time = value;
			REG_ZERO_BIT:  line_cfg.zero_bit  = value;
			REG_ONE_BIT:   line_cfg.one_bit   = value;
			REG_SYNC_BIT:  line_cfg.sync_bit  = value;
			REG_SYNC_REPS: line_cfg.sync_reps = value[SYNC_REG_W-1:0];
			REG_INVERT:    line_cfg.invert    = value[0];
			default: ;
		endcase
	endtask

	task automatic end_writes;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drain the block, then program all six registers.
	task automatic apply_settings(input line_cfg_t c);
		wait_drained();
		write_register(REG_HIGH_TIME, c.high_time);
		write_register(REG_ZERO_BIT, c.zero_bit);
		write_register(REG_ONE_BIT, c.one_bit);
		write_register(REG_SYNC_BIT, c.sync_bit);
		write_register(REG_SYNC_REPS, CFG_DATA_W'(c.sync_reps));
		write_register(REG_INVERT, CFG_DATA_W'(c.invert));
		end_writes();
		settings_applied++;
	endtask

	function automatic logic [DUR_W-1:0] pick_period();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return DUR_W'(1);
			2: return '1;
			3: return DUR_W'($urandom);
			default: return DUR_W'($urandom_range(1, 200));
		endcase
	endfunction

	function automatic line_cfg_t random_settings();
		line_cfg_t c;
		c.high_time = pick_period();
		c.zero_bit  = pick_period();
		c.one_bit   = pick_period();
		c.sync_bit  = pick_period();
		c.sync_reps = SYNC_REG_W'($urandom_range(0, 15));
		c.invert    = 1'($urandom_range(0, 1));
		return c;
	endfunction

	function automatic line_cfg_t settings_of(input int hi, input int zero, input int one,
			input int sync, input int count, input logic inv);
		line_cfg_t c;
		c.high_time = DUR_W'(hi);
		c.zero_bit  = DUR_W'(zero);
		c.one_bit   = DUR_W'(one);
		c.sync_bit  = DUR_W'(sync);
		c.sync_reps = SYNC_REG_W'(count);
		c.invert    = inv;
		return c;
	endfunction

	// Reset settings: a one-byte message, then a three-byte message.
	task automatic test_reset_defaults;
		send_request(8'hA5, 1'b1);
		send_request(8'h00, 1'b0);
		send_request(8'hFF, 1'b0);
		send_request(8'h5A, 1'b1);
	endtask

	// Single set and single clear bits at both ends of the byte, with inverted output.
	task automatic test_byte_extremes;
		apply_settings(settings_of(7, 30, 55, 90, 2, 1'b1));
		send_request(8'h80, 1'b0);
		send_request(8'h01, 1'b1);
		send_request(8'h7F, 1'b1);
		send_request(8'hFE, 1'b0);
	endtask

	// Bit and sync periods not longer than the high time give zero-length lows.
	task automatic test_short_periods;
		apply_settings(settings_of(100, 100, 50, 1, 15, 1'b0));
		send_request(8'h3C, 1'b1);
		send_request(8'hC3, 1'b1);
	endtask

	// Zero high time with no sync pulses; the lows are the full periods.
	task automatic test_zero_high_time;
		apply_settings(settings_of(0, 65535, 1, 65535, 0, 1'b0));
		send_request(8'h96, 1'b0);
		send_request(8'h69, 1'b0);
		send_request(8'hF0, 1'b1);
	endtask

	// Full-scale values everywhere, the longest requests.
	task automatic test_full_scale;
		apply_settings(settings_of(65535, 65535, 65535, 65535, 15, 1'b1));
		send_request(8'h0F, 1'b0);
		send_request(8'hAA, 1'b1);
	endtask

	// Writes to indexes past the last register must leave the settings alone.
	task automatic test_spare_indexes;
		apply_settings(settings_of(12, 25, 45, 70, 3, 1'b0));
		write_register(REG_SPARE_LO, '1);
		write_register(REG_SPARE_HI, 16'h5555);
		end_writes();
		send_request(8'h55, 1'b1);
		send_request(8'hC0, 1'b1);
	endtask

	// Random messages under changing settings; the last phase runs without idling.
	task automatic test_random_messages;
		line_cfg_t c;
		int n_items;
		for (int p = 0; p < 9; p++) begin
			if (p == 0)
				c = settings_of(65535, 65535, 65535, 65535, 15, 1'b0);
			else if (p == 1)
				c = settings_of(1, 1, 1, 1, 1, 1'b1);
			else
				c = random_settings();
			if (p == 8)
				idling_on = 1'b0;
			apply_settings(c);
			n_items = (p == 8) ? 50 : 45;
			for (int k = 0; k < n_items; k++) begin
				// Hold off once mid-phase until the block has emptied.
				if (p == 4 && k == 20)
					wait_drained();
				send_request(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end
		end
	endtask

	// Main sequence.
	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_idx           = '0;
		cfg_wdata         = '0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.last_byte = 1'b0;
		seg_ch.ready      = 1'b0;
		line_cfg          = settings_of(10, 20, 40, 80, 1, 1'b0);
		frame_open        = 1'b0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_byte_extremes();
		test_short_periods();
		test_zero_high_time();
		test_full_scale();
		test_spare_indexes();
		test_random_messages();

		wait_drained();
		repeat (8) @(posedge clk);
		if (pending_segments.size() != 0)
			report_mismatch($sformatf("%0d predicted segments never arrived",
				pending_segments.size()));

		$display("Sent %0d byte requests under %0d register settings, checked %0d segments.",
			requests_sent, settings_applied, segments_checked);
		$display("Covered zero and full-scale periods, sync counts 0 to 15, and inversion.");
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
